// ===== rtl/pcx_pkg.sv =====
package pcx_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [16:0] image_width;
        logic [16:0] image_height;
        logic        last_pixel;
        logic        header_error;
    } t_out_item;

    localparam logic [7:0] MAGIC_ID   = 8'd10;
    localparam logic [7:0] MAGIC_VER  = 8'd5;
    localparam logic [7:0] RUN_MARK   = 8'hbf;

    localparam logic [7:0] POS_VER     = 8'd1;
    localparam logic [7:0] POS_XMIN_LO = 8'd4;
    localparam logic [7:0] POS_XMIN_HI = 8'd5;
    localparam logic [7:0] POS_YMIN_LO = 8'd6;
    localparam logic [7:0] POS_YMIN_HI = 8'd7;
    localparam logic [7:0] POS_XMAX_LO = 8'd8;
    localparam logic [7:0] POS_XMAX_HI = 8'd9;
    localparam logic [7:0] POS_YMAX_LO = 8'd10;
    localparam logic [7:0] POS_YMAX_HI = 8'd11;

    // shift-add steps for the 17 x 17 bit pixel count product
    localparam logic [4:0] MUL_STEPS = 5'd17;

endpackage

// ===== rtl/pcx_rle_image_decoder.sv =====
// PCX run-length image decoder.
// Input channel (i_in_valid / o_in_stall / i_in): one file byte per transaction;
// file_start marks header byte 0 and restarts the decoder at any point.
// Output channel (o_out_valid / i_out_stall / o_out): one decoded pixel per
// transaction, with the image width and height and a flag on the final pixel.
// A wrong magic byte gives a single transaction with header_error set; further
// bytes are then dropped until the next file_start.
// Header and literal bytes are taken back to back while the output register is
// free. After the last header byte the pixel count width*height is formed by a
// 17-step shift-add loop on the single 33-bit adder with the input stalled. A run
// byte pair gives up to 63 pixels, one per cycle unless the receiver stalls, the
// first in the cycle the value byte is taken; the same adder counts the pixels
// down, so the input is stalled for the rest of the run. Results leave from a single
// output register, in the cycle after the byte that causes them. While the
// receiver stalls, that register holds and the input stalls whenever it is full.
// Reset idles the decoder, empties the output register and waits for a byte
// flagged file_start.
module pcx_rle_image_decoder #(
    parameter int HEADER_BYTES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pcx_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pcx_pkg::t_out_item  o_out
);
    import pcx_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HEADER = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DATA   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic [8:0] HDR_LEN = 9'(HEADER_BYTES);

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_pos, n_pos;
    logic [15:0] r_x_min, n_x_min, r_y_min, n_y_min;
    logic [15:0] r_x_max, n_x_max, r_y_max, n_y_max;
    logic [32:0] r_pixels_left, n_pixels_left;
    logic [32:0] r_mcand, n_mcand;
    logic [16:0] r_mplier, n_mplier;
    logic [4:0]  r_mul_cnt, n_mul_cnt;
    logic [5:0]  r_run_count, n_run_count;
    logic        r_run_pending, n_run_pending;
    logic [5:0]  r_count, n_count;
    logic [7:0]  r_value, n_value;
    logic        r_out_vld, n_out_vld;
    t_out_item   r_out, n_out;

    logic        out_free;
    logic        accept;
    logic [32:0] add_b;
    logic [32:0] add_sum;
    logic [16:0] w_span, h_span;
    logic        do_emit;
    logic [7:0]  emit_val;
    logic [5:0]  emit_cnt;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state inside {ST_LOAD, ST_MUL, ST_EMIT}) || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign w_span = {1'b0, r_x_max - r_x_min} + 17'd1;
    assign h_span = {1'b0, r_y_max - r_y_min} + 17'd1;

    // shared adder: accumulate during multiply, else count down by one
    assign add_b   = (r_state == ST_MUL) ? r_mcand : {33{1'b1}};
    assign add_sum = r_pixels_left + add_b;

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_x_min       = r_x_min;
        n_y_min       = r_y_min;
        n_x_max       = r_x_max;
        n_y_max       = r_y_max;
        n_pixels_left = r_pixels_left;
        n_mcand       = r_mcand;
        n_mplier      = r_mplier;
        n_mul_cnt     = r_mul_cnt;
        n_run_count   = r_run_count;
        n_run_pending = r_run_pending;
        n_count       = r_count;
        n_value       = r_value;
        n_out_vld     = r_out_vld && i_out_stall;
        n_out         = r_out;
        do_emit       = 1'b0;
        emit_val      = r_value;
        emit_cnt      = r_count;

        case (r_state)
            ST_LOAD: begin
                n_mcand       = {16'd0, w_span};
                n_mplier      = h_span;
                n_pixels_left = '0;
                n_mul_cnt     = '0;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                if (r_mplier[0]) begin
                    n_pixels_left = add_sum;
                end
                n_mcand   = {r_mcand[31:0], 1'b0};
                n_mplier  = {1'b0, r_mplier[16:1]};
                n_mul_cnt = r_mul_cnt + 5'd1;
                if (r_mul_cnt == MUL_STEPS - 5'd1) begin
                    n_state = ST_DATA;
                end
            end
            ST_EMIT: begin
                do_emit = out_free;
            end
            default: begin
                if (accept) begin
                    if (i_in.file_start) begin
                        n_x_min       = '0;
                        n_y_min       = '0;
                        n_x_max       = '0;
                        n_y_max       = '0;
                        n_run_count   = '0;
                        n_run_pending = 1'b0;
                        n_pixels_left = '0;
                        n_pos         = 8'd1;
                        n_state       = ST_HEADER;
                        if (i_in.data_byte != MAGIC_ID) begin
                            n_out_vld = 1'b1;
                            n_out     = '0;
                            n_out.header_error = 1'b1;
                            n_state   = ST_DONE;
                        end
                    end else if (r_state == ST_HEADER) begin
                        if (r_pos == POS_VER && i_in.data_byte != MAGIC_VER) begin
                            n_out_vld = 1'b1;
                            n_out     = '0;
                            n_out.header_error = 1'b1;
                            n_state   = ST_DONE;
                        end else begin
                            case (r_pos)
                                POS_XMIN_LO: n_x_min[7:0]  = i_in.data_byte;
                                POS_XMIN_HI: n_x_min[15:8] = i_in.data_byte;
                                POS_YMIN_LO: n_y_min[7:0]  = i_in.data_byte;
                                POS_YMIN_HI: n_y_min[15:8] = i_in.data_byte;
                                POS_XMAX_LO: n_x_max[7:0]  = i_in.data_byte;
                                POS_XMAX_HI: n_x_max[15:8] = i_in.data_byte;
                                POS_YMAX_LO: n_y_max[7:0]  = i_in.data_byte;
                                POS_YMAX_HI: n_y_max[15:8] = i_in.data_byte;
                                default: ;
                            endcase
                            if ({1'b0, r_pos} + 9'd1 >= HDR_LEN) begin
                                n_state = ST_LOAD;
                            end else begin
                                n_pos = r_pos + 8'd1;
                            end
                        end
                    end else if (r_state == ST_DATA) begin
                        if (r_run_pending) begin
                            n_run_pending = 1'b0;
                            n_run_count   = '0;
                            if (r_run_count != 6'd0) begin
                                do_emit  = 1'b1;
                                emit_val = i_in.data_byte;
                                emit_cnt = r_run_count;
                            end
                        end else if (i_in.data_byte > RUN_MARK) begin
                            n_run_count   = i_in.data_byte[5:0];
                            n_run_pending = 1'b1;
                        end else begin
                            do_emit  = 1'b1;
                            emit_val = i_in.data_byte;
                            emit_cnt = 6'd1;
                        end
                    end
                end
            end
        endcase

        if (do_emit) begin
            n_out_vld                = 1'b1;
            n_out.pixel_value        = emit_val;
            n_out.image_width        = w_span;
            n_out.image_height       = h_span;
            n_out.last_pixel         = (r_pixels_left == 33'd1);
            n_out.header_error       = 1'b0;
            n_pixels_left            = add_sum;
            n_value                  = emit_val;
            n_count                  = emit_cnt - 6'd1;
            if (add_sum == 33'd0) begin
                n_state = ST_DONE;
            end else if (emit_cnt > 6'd1) begin
                n_state = ST_EMIT;
            end else begin
                n_state = ST_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_vld     <= 1'b0;
            r_pos         <= '0;
            r_run_pending <= 1'b0;
            r_run_count   <= '0;
        end else begin
            r_state       <= n_state;
            r_out_vld     <= n_out_vld;
            r_pos         <= n_pos;
            r_run_pending <= n_run_pending;
            r_run_count   <= n_run_count;
        end
        r_x_min       <= n_x_min;
        r_y_min       <= n_y_min;
        r_x_max       <= n_x_max;
        r_y_max       <= n_y_max;
        r_pixels_left <= n_pixels_left;
        r_mcand       <= n_mcand;
        r_mplier      <= n_mplier;
        r_mul_cnt     <= n_mul_cnt;
        r_count       <= n_count;
        r_value       <= n_value;
        r_out         <= n_out;
    end

endmodule

// ===== sim/pcx_rle_image_decoder_test.sv =====
`timescale 1ns / 1ps

module pcx_rle_image_decoder_test;

    import pcx_pkg::*;

    localparam int HDR_LEN      = 128;
    localparam int RANDOM_ITEMS = 370;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [7:0] POS_ID     = 8'd0;
    localparam logic [7:0] RUN_FLAGS  = 8'hc0;
    localparam logic [7:0] COUNT_MASK = 8'h3f;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_HEADER,
        DEC_PIXELS,
        DEC_DONE
    } t_dec_phase;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in        = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out;

    t_in_item   byte_q[$];
    t_out_item  pixel_q[$];

    int n_items       = 0;
    int n_fail        = 0;
    int n_cycles      = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 81;

    // decoder state as predicted
    t_dec_phase  dec_phase   = DEC_IDLE;
    logic [7:0]  hdr_pos     = '0;
    logic [15:0] lo_x        = '0;
    logic [15:0] lo_y        = '0;
    logic [15:0] hi_x        = '0;
    logic [15:0] hi_y        = '0;
    logic [32:0] px_left     = '0;
    logic [5:0]  rep_count   = '0;
    logic        rep_armed   = 1'b0;

    pcx_rle_image_decoder #(
        .HEADER_BYTES (HDR_LEN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [16:0] extent(input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] diff;
        diff = hi - lo;
        return {1'b0, diff} + 17'd1;
    endfunction

    task automatic emit_pixels(input logic [7:0] value, input int count);
        t_out_item px;
        int        n;
        n = count;
        while (n > 0 && px_left != 0) begin
            px.pixel_value  = value;
            px.image_width  = extent(lo_x, hi_x);
            px.image_height = extent(lo_y, hi_y);
            px.last_pixel   = (px_left == 33'd1);
            px.header_error = 1'b0;
            pixel_q.push_back(px);
            px_left = px_left - 33'd1;
            n--;
        end
        if (px_left == 0)
            dec_phase = DEC_DONE;
    endtask

    task automatic predict_byte(input t_in_item it);
        t_out_item   fault;
        logic [7:0]  b;
        b = it.data_byte;
        if (it.file_start) begin
            hdr_pos   = '0;
            lo_x      = '0;
            lo_y      = '0;
            hi_x      = '0;
            hi_y      = '0;
            px_left   = '0;
            rep_count = '0;
            rep_armed = 1'b0;
            dec_phase = DEC_HEADER;
        end
        case (dec_phase)
            DEC_HEADER: begin
                if ((hdr_pos == POS_ID && b != MAGIC_ID) ||
                    (hdr_pos == POS_VER && b != MAGIC_VER)) begin
                    dec_phase = DEC_DONE;
                    fault = '0;
                    fault.header_error = 1'b1;
                    pixel_q.push_back(fault);
                end else begin
                    case (hdr_pos)
                        POS_XMIN_LO: lo_x[7:0]  = b;
                        POS_XMIN_HI: lo_x[15:8] = b;
                        POS_YMIN_LO: lo_y[7:0]  = b;
                        POS_YMIN_HI: lo_y[15:8] = b;
                        POS_XMAX_LO: hi_x[7:0]  = b;
                        POS_XMAX_HI: hi_x[15:8] = b;
                        POS_YMAX_LO: hi_y[7:0]  = b;
                        POS_YMAX_HI: hi_y[15:8] = b;
                        default: ;
                    endcase
                    if (int'(hdr_pos) + 1 >= HDR_LEN) begin
                        px_left   = 33'(extent(lo_x, hi_x)) * 33'(extent(lo_y, hi_y));
                        dec_phase = DEC_PIXELS;
                    end else begin
                        hdr_pos = hdr_pos + 8'd1;
                    end
                end
            end
            DEC_PIXELS: begin
                if (rep_armed) begin
                    rep_armed = 1'b0;
                    emit_pixels(b, int'(rep_count));
                    rep_count = '0;
                end else if (b > RUN_MARK) begin
                    rep_count = b[5:0];
                    rep_armed = 1'b1;
                end else begin
                    emit_pixels(b, 1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start, input bit counted);
        t_in_item it;
        it.data_byte  = b;
        it.file_start = start;
        byte_q.push_back(it);
        if (counted)
            n_items++;
    endtask

    task automatic push_header(input logic [15:0] xlo, input logic [15:0] ylo,
                               input logic [15:0] xhi, input logic [15:0] yhi);
        for (int pos = 0; pos < HDR_LEN; pos++) begin
            case (8'(pos))
                POS_ID:      push_byte(MAGIC_ID, 1'b1, 1'b1);
                POS_VER:     push_byte(MAGIC_VER, 1'b0, 1'b1);
                POS_XMIN_LO: push_byte(xlo[7:0], 1'b0, 1'b1);
                POS_XMIN_HI: push_byte(xlo[15:8], 1'b0, 1'b1);
                POS_YMIN_LO: push_byte(ylo[7:0], 1'b0, 1'b1);
                POS_YMIN_HI: push_byte(ylo[15:8], 1'b0, 1'b1);
                POS_XMAX_LO: push_byte(xhi[7:0], 1'b0, 1'b1);
                POS_XMAX_HI: push_byte(xhi[15:8], 1'b0, 1'b1);
                POS_YMAX_LO: push_byte(yhi[7:0], 1'b0, 1'b1);
                POS_YMAX_HI: push_byte(yhi[15:8], 1'b0, 1'b1);
                default:     push_byte(8'($urandom_range(255)), 1'b0, pos < 12);
            endcase
        end
    endtask

    task automatic build_directed();
        // stray bytes before any file, then both magic failures
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h0b, 1'b1, 1'b0);
        push_byte(MAGIC_ID, 1'b0, 1'b0);
        push_byte(MAGIC_ID, 1'b1, 1'b0);
        push_byte(8'h04, 1'b0, 1'b0);
        // restart part way through a header
        push_byte(MAGIC_ID, 1'b1, 1'b0);
        push_byte(MAGIC_VER, 1'b0, 1'b0);
        push_byte(8'h33, 1'b0, 1'b0);
        // 4 x 1 with wrapped x bounds; literal 0x00, zero run, literal 0xbf, clipped run, trailing bytes
        push_header(16'hfffe, 16'h0005, 16'h0001, 16'h0005);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(RUN_FLAGS, 1'b0, 1'b0);
        push_byte(8'h77, 1'b0, 1'b0);
        push_byte(RUN_MARK, 1'b0, 1'b0);
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'ha5, 1'b0, 1'b0);
        push_byte(8'hc3, 1'b0, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0);
        // 65536 x 65536, full run, run of one, then restart with a run pending
        push_header(16'h0000, 16'hffff, 16'hffff, 16'hfffe);
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'hc1, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'hc5, 1'b0, 1'b0);
        // 1 x 1 from a run of one
        push_header(16'h1234, 16'h1234, 16'h1234, 16'h1234);
        push_byte(8'hc1, 1'b0, 1'b0);
        push_byte(8'h5a, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        // 1 x 1 from a literal
        push_header(16'h8000, 16'h0000, 16'h8000, 16'h0000);
        push_byte(RUN_MARK, 1'b0, 1'b0);
    endtask

    task automatic build_random_file();
        int          kind;
        int          w;
        int          h;
        int          left;
        int          cnt;
        int          tokens;
        int          stop_at;
        bit          big;
        logic [15:0] xlo;
        logic [15:0] ylo;
        kind = $urandom_range(99);
        if (kind < 8) begin
            if (kind < 4) begin
                push_byte(8'($urandom_range(255)) ^ MAGIC_ID | 8'h01, 1'b1, 1'b1);
            end else begin
                push_byte(MAGIC_ID, 1'b1, 1'b1);
                push_byte(8'($urandom_range(255)) ^ MAGIC_VER | 8'h02, 1'b0, 1'b1);
            end
            repeat ($urandom_range(4)) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            return;
        end
        big   = (kind < 14);
        xlo   = 16'($urandom);
        ylo   = 16'($urandom);
        w     = big ? $urandom_range(200, 65536) : $urandom_range(1, 8);
        h     = big ? $urandom_range(1, 65536) : $urandom_range(1, 6);
        push_header(xlo, ylo, xlo + 16'(w - 1), ylo + 16'(h - 1));
        left    = big ? 1000000 : w * h;
        stop_at = $urandom_range(3, 12);
        tokens  = 0;
        while (left > 0) begin
            if (big && tokens >= stop_at)
                break;
            if (!big && $urandom_range(99) < 4)
                break;
            tokens++;
            if ($urandom_range(99) < 60) begin
                push_byte(8'($urandom_range(RUN_MARK)), 1'b0, 1'b1);
                left--;
            end else begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
                push_byte(RUN_FLAGS | (8'(cnt) & COUNT_MASK), 1'b0, 1'b1);
                push_byte(8'($urandom_range(255)), 1'b0, 1'b1);
                left -= (cnt < left) ? cnt : left;
            end
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_byte(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= byte_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected transaction: pix %02h w %0d h %0d last %0b err %0b",
                                 o_out.pixel_value, o_out.image_width, o_out.image_height,
                                 o_out.last_pixel, o_out.header_error);
                end else begin
                    want = pixel_q.pop_front();
                    if (want.pixel_value  !== o_out.pixel_value  ||
                        want.image_width  !== o_out.image_width  ||
                        want.image_height !== o_out.image_height ||
                        want.last_pixel   !== o_out.last_pixel   ||
                        want.header_error !== o_out.header_error) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $write("mismatch: exp pix %02h w %0d h %0d last %0b err %0b,",
                                   want.pixel_value, want.image_width, want.image_height,
                                   want.last_pixel, want.header_error);
                            $display(" got pix %02h w %0d h %0d last %0b err %0b",
                                     o_out.pixel_value, o_out.image_width, o_out.image_height,
                                     o_out.last_pixel, o_out.header_error);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        build_directed();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 81;
                recv_idle_pct = 20;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (n_items < (ph + 1) * RANDOM_ITEMS / 3)
                build_random_file();
            while (byte_q.size() != 0 || i_in_valid)
                @(posedge i_clk);
        end
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && pixel_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pcx_pkg.sv
rtl/pcx_rle_image_decoder.sv
sim/pcx_rle_image_decoder_test.sv
